[src/dpia_pkg.sv]
package dpia_pkg;

	// fixed field widths
	localparam int HANDLE_W  = 9;
	localparam int COUNT_W   = 8;
	localparam int SLOT_W    = 8;
	localparam int WORD_W    = 32;
	localparam int NUM_WORDS = 8;
	localparam int WIDX_W    = 3;
	localparam int BIT_W     = 5;
	localparam int QDEPTH    = 2;
	localparam int QPTR_W    = 1;
	localparam int QCNT_W    = 2;

	typedef enum logic [1:0] {
		OP_ALLOC   = 2'd0,
		OP_RELEASE = 2'd1,
		OP_CHECK   = 2'd2,
		OP_NONE    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		STS_OK        = 2'd0,
		STS_EXHAUSTED = 2'd1,
		STS_RANGE     = 2'd2,
		STS_NOT_USED  = 2'd3
	} sts_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_SCAN,
		BK_RESP
	} back_state_t;

	// classified request passed from front to back
	typedef struct packed {
		op_t               op;
		logic              pool;
		logic [SLOT_W-1:0] slot;
		logic              in_range;
	} dpia_req_t;

endpackage

[src/dpia_front.sv]
module dpia_front import dpia_pkg::*; #(
	parameter int POOL_SIZE   = 255,
	parameter int HANDLE_BASE = 2
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          opcode,
	input  logic                pool,
	input  logic [HANDLE_W-1:0] handle_in,
	output logic                req_valid,
	output dpia_req_t           req,
	input  logic                req_pop
);

	localparam logic [HANDLE_W:0] BASE_X = (HANDLE_W+1)'(HANDLE_BASE);
	localparam logic [HANDLE_W:0] SIZE_X = (HANDLE_W+1)'(POOL_SIZE);

	dpia_req_t         q_mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic [HANDLE_W:0] diff;
	dpia_req_t         cls;
	logic              push;

	// classify the incoming word: range test and slot number
	always_comb begin
		diff         = {1'b0, handle_in} - BASE_X;
		cls.op       = op_t'(opcode);
		cls.pool     = pool;
		cls.slot     = diff[SLOT_W-1:0];
		cls.in_range = ({1'b0, handle_in} >= BASE_X) && (diff < SIZE_X);
	end

	assign in_ready  = (cnt_q != QCNT_W'(QDEPTH));
	assign push      = in_valid && in_ready;
	assign req_valid = (cnt_q != '0);
	assign req       = q_mem_q[rd_ptr_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_ptr_q] <= cls;
		end
	end

	// queue pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (req_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, req_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

[src/dpia_back.sv]
module dpia_back import dpia_pkg::*; #(
	parameter int POOL_SIZE   = 255,
	parameter int HANDLE_BASE = 2
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	input  dpia_req_t           req,
	output logic                req_pop,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [1:0]          status,
	output logic [HANDLE_W-1:0] handle_out,
	output logic [COUNT_W-1:0]  free_count
);

	localparam logic [WIDX_W-1:0]  LAST_WORD = WIDX_W'((POOL_SIZE - 1) / WORD_W);
	localparam logic [SLOT_W:0]    SIZE_X    = (SLOT_W+1)'(POOL_SIZE);
	localparam logic [COUNT_W-1:0] SIZE_CNT  = COUNT_W'(POOL_SIZE);

	back_state_t          state_q, state_d;
	dpia_req_t            cur_q;
	logic [WIDX_W-1:0]    w_q;
	logic [BIT_W-1:0]     bit_q;
	logic                 found_q;
	logic [WORD_W-1:0]    used_q [2][NUM_WORDS];
	logic [COUNT_W-1:0]   cnt_q [2];
	logic                 out_valid_q;
	logic [1:0]           status_q;
	logic [HANDLE_W-1:0]  handle_q;
	logic [COUNT_W-1:0]   count_q;

	logic [WIDX_W-1:0]    widx;
	logic [BIT_W-1:0]     bidx;
	logic [WORD_W-1:0]    rd_word;
	logic [WORD_W-1:0]    vmask;
	logic [WORD_W-1:0]    free_bits;
	logic [WORD_W-1:0]    lowest;
	logic [BIT_W-1:0]     low_idx;
	logic                 any_free;
	logic                 out_load;
	logic                 bit_used;
	sts_t                 res_status;
	logic [HANDLE_W-1:0]  res_handle;
	logic [COUNT_W-1:0]   res_count;
	logic                 do_set;
	logic                 do_clr;

	// one bitmap word per cycle: scan word for allocate, slot word otherwise
	always_comb begin
		widx     = (cur_q.op == OP_ALLOC) ? w_q : cur_q.slot[SLOT_W-1 -: WIDX_W];
		bidx     = (cur_q.op == OP_ALLOC) ? bit_q : cur_q.slot[BIT_W-1:0];
		rd_word  = used_q[cur_q.pool][widx];
		bit_used = rd_word[bidx];
	end

	// lowest free slot in the current word
	always_comb begin
		for (int b = 0; b < WORD_W; b++) begin
			vmask[b] = ((SLOT_W+1)'({w_q, BIT_W'(b)}) < SIZE_X);
		end
		free_bits = ~rd_word & vmask;
		lowest    = free_bits & (~free_bits + 1'b1);
		any_free  = |free_bits;
		low_idx   = '0;
		for (int b = 0; b < WORD_W; b++) begin
			if (lowest[b]) begin
				low_idx = low_idx | BIT_W'(b);
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (req_valid) begin
					state_d = (req.op == OP_ALLOC) ? BK_SCAN : BK_RESP;
				end
			end
			BK_SCAN: begin
				if (any_free || (w_q == LAST_WORD)) begin
					state_d = BK_RESP;
				end
			end
			BK_RESP: begin
				if (out_load) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	// state machine outputs
	always_comb begin
		req_pop  = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			BK_IDLE: req_pop  = req_valid;
			BK_SCAN: req_pop  = 1'b0;
			BK_RESP: out_load = !out_valid_q || out_ready;
			default: req_pop  = 1'b0;
		endcase
	end

	// result of the request and the bitmap/count update it makes
	always_comb begin
		res_status = STS_OK;
		res_handle = '0;
		res_count  = cnt_q[cur_q.pool];
		do_set     = 1'b0;
		do_clr     = 1'b0;
		case (cur_q.op)
			OP_ALLOC: begin
				if (found_q) begin
					res_handle = HANDLE_W'({w_q, bit_q}) + HANDLE_W'(HANDLE_BASE);
					res_count  = cnt_q[cur_q.pool] - 1'b1;
					do_set     = 1'b1;
				end else begin
					res_status = STS_EXHAUSTED;
				end
			end
			OP_RELEASE: begin
				if (!cur_q.in_range) begin
					res_status = STS_RANGE;
				end else if (!bit_used) begin
					res_status = STS_NOT_USED;
				end else begin
					res_count = cnt_q[cur_q.pool] + 1'b1;
					do_clr    = 1'b1;
				end
			end
			OP_CHECK: begin
				if (!cur_q.in_range) begin
					res_status = STS_RANGE;
				end else if (!bit_used) begin
					res_status = STS_NOT_USED;
				end
			end
			default: res_status = STS_OK;
		endcase
	end

	// control registers, bitmaps and free counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			out_valid_q <= 1'b0;
			found_q     <= 1'b0;
			w_q         <= '0;
			bit_q       <= '0;
			for (int p = 0; p < 2; p++) begin
				cnt_q[p] <= SIZE_CNT;
				for (int w = 0; w < NUM_WORDS; w++) begin
					used_q[p][w] <= '0;
				end
			end
		end else begin
			state_q <= state_d;
			if (req_pop) begin
				w_q     <= '0;
				found_q <= 1'b0;
			end else if (state_q == BK_SCAN) begin
				if (any_free) begin
					found_q <= 1'b1;
					bit_q   <= low_idx;
				end else if (w_q != LAST_WORD) begin
					w_q <= w_q + 1'b1;
				end
			end
			if (out_load) begin
				cnt_q[cur_q.pool] <= res_count;
				if (do_set) begin
					used_q[cur_q.pool][widx][bidx] <= 1'b1;
				end else if (do_clr) begin
					used_q[cur_q.pool][widx][bidx] <= 1'b0;
				end
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// request and output word payload
	always_ff @(posedge clk) begin
		if (req_pop) begin
			cur_q <= req;
		end
		if (out_load) begin
			status_q <= res_status;
			handle_q <= res_handle;
			count_q  <= res_count;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign handle_out = handle_q;
	assign free_count = count_q;

endmodule

[src/dual_pool_index_allocator.sv]
// order: release, check and unused opcodes pass from the queue to the back end request
// register and then the output register; allocate first scans the 32-bit bitmap words
// for a free slot; one request at a time in the back end, so a new one leaves the queue
// only once the last reply is loaded; a 2-word queue keeps the input open while it works
// reset: arst_n clears both bitmaps to all free, sets both free counts to the pool size
// and empties the queue and output register at once; no clearing pass is needed
module dual_pool_index_allocator import dpia_pkg::*; #(
	parameter int POOL_SIZE   = 255,
	parameter int HANDLE_BASE = 2
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          opcode,
	input  logic                pool,
	input  logic [HANDLE_W-1:0] handle_in,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [1:0]          status,
	output logic [HANDLE_W-1:0] handle_out,
	output logic [COUNT_W-1:0]  free_count
);

	logic      req_valid;
	logic      req_pop;
	dpia_req_t req;

	// classify and queue
	dpia_front #(
		.POOL_SIZE   (POOL_SIZE),
		.HANDLE_BASE (HANDLE_BASE)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.opcode    (opcode),
		.pool      (pool),
		.handle_in (handle_in),
		.req_valid (req_valid),
		.req       (req),
		.req_pop   (req_pop)
	);

	// bitmap scan and update
	dpia_back #(
		.POOL_SIZE   (POOL_SIZE),
		.HANDLE_BASE (HANDLE_BASE)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req        (req),
		.req_pop    (req_pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.handle_out (handle_out),
		.free_count (free_count)
	);

`ifndef SYNTH
	// an exhausted pool has no free slots left
	a_exhausted_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == STS_EXHAUSTED) |-> (free_count == '0))
		else $error("exhausted reported with free slots");

	// only a successful allocate returns a nonzero handle
	a_handle_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (handle_out != '0) |-> (status == STS_OK))
		else $error("handle returned with failing status");

	// free count never exceeds pool size
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (free_count <= COUNT_W'(POOL_SIZE)))
		else $error("free count above pool size");
`endif

endmodule

[tb/dpia_reply_checker.sv]
module dpia_reply_checker import dpia_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_ready,
	input  logic [1:0]          opcode,
	input  logic                pool,
	input  logic [HANDLE_W-1:0] handle_in,
	input  logic                out_valid,
	input  logic                out_ready,
	input  logic [1:0]          status,
	input  logic [HANDLE_W-1:0] handle_out,
	input  logic [COUNT_W-1:0]  free_count,
	output int                  fail_count,
	output int                  pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS = 255;
	localparam int BASE  = 2;

	// one reply word as the block should return it
	typedef struct packed {
		sts_t                st;
		logic [HANDLE_W-1:0] hnd;
		logic [COUNT_W-1:0]  cnt;
	} reply_t;

	// shadow copy of both pools
	bit                 used_map [2][SLOTS];
	logic [COUNT_W-1:0] free_left [2];
	reply_t             reply_q [$];

	// apply one request to the shadow pools and return the reply it earns
	function automatic reply_t apply_request(op_t op, logic p, logic [HANDLE_W-1:0] h);
		reply_t r;
		int     slot;
		bit     in_pool;
		bit     found;
		r.st    = STS_OK;
		r.hnd   = '0;
		found   = 1'b0;
		in_pool = (int'(h) >= BASE) && (int'(h) - BASE < SLOTS);
		slot    = in_pool ? int'(h) - BASE : 0;
		case (op)
			OP_ALLOC: begin
				// lowest free slot wins
				r.st = STS_EXHAUSTED;
				for (int i = 0; i < SLOTS; i++) begin
					if (!found && !used_map[p][i]) begin
						found          = 1'b1;
						used_map[p][i] = 1'b1;
						if (free_left[p] != 0)
							free_left[p]--;
						r.hnd = HANDLE_W'(i + BASE);
						r.st  = STS_OK;
					end
				end
			end
			OP_RELEASE: begin
				if (!in_pool)
					r.st = STS_RANGE;
				else if (!used_map[p][slot])
					r.st = STS_NOT_USED;
				else begin
					used_map[p][slot] = 1'b0;
					if (free_left[p] < COUNT_W'(SLOTS))
						free_left[p]++;
				end
			end
			OP_CHECK: begin
				if (!in_pool)
					r.st = STS_RANGE;
				else if (!used_map[p][slot])
					r.st = STS_NOT_USED;
			end
			default: begin
				// unused opcode only reports the count
			end
		endcase
		r.cnt = free_left[p];
		return r;
	endfunction

	// predict on accepted requests, compare on accepted replies
	always @(posedge clk or negedge arst_n) begin
		reply_t want;
		if (!arst_n) begin
			foreach (used_map[pi, si])
				used_map[pi][si] = 1'b0;
			free_left[0] = COUNT_W'(SLOTS);
			free_left[1] = COUNT_W'(SLOTS);
			reply_q.delete();
			fail_count = 0;
			pending    = 0;
		end else begin
			// returned word against the oldest prediction
			if (out_valid && out_ready) begin
				if (reply_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected reply word: status %0d handle %0d free %0d",
							status, handle_out, free_count);
				end else begin
					want = reply_q.pop_front();
					if (status !== want.st || handle_out !== want.hnd ||
						free_count !== want.cnt) begin
						fail_count++;
						if (fail_count <= 10)
							$display({"reply mismatch: status exp %0d got %0d, ",
								"handle exp %0d got %0d, free exp %0d got %0d"},
								want.st, status, want.hnd, handle_out,
								want.cnt, free_count);
					end
				end
			end
			// accepted request goes through the shadow pools
			if (in_valid && in_ready)
				reply_q.push_back(apply_request(op_t'(opcode), pool, handle_in));
			pending = reply_q.size();
		end
	end

endmodule

[tb/dual_pool_index_allocator_tb.sv]
module dual_pool_index_allocator_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import dpia_pkg::*;

	localparam int HANDLE_LO = 2;
	localparam int HANDLE_HI = 256;

	logic                clk        = 1'b0;
	logic                arst_n     = 1'b0;
	logic                in_valid   = 1'b0;
	logic                in_ready;
	logic [1:0]          opcode     = OP_ALLOC;
	logic                pool       = 1'b0;
	logic [HANDLE_W-1:0] handle_in  = '0;
	logic                out_valid;
	logic                out_ready  = 1'b0;
	logic [1:0]          status;
	logic [HANDLE_W-1:0] handle_out;
	logic [COUNT_W-1:0]  free_count;
	int                  fail_count;
	int                  pending;
	bit                  quiet      = 1'b0;
	int                  ready_gap  = 0;

	// 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	dual_pool_index_allocator u_top (.*);

	dpia_reply_checker u_checker (.*);

	// random stall bursts on the reply side
	always @(posedge clk) begin
		if (ready_gap == 0 && !quiet && $urandom_range(0, 5) == 0)
			ready_gap = $urandom_range(1, 6);
		if (ready_gap > 0) begin
			out_ready <= 1'b0;
			ready_gap--;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// handle that lands inside a pool
	function automatic logic [HANDLE_W-1:0] pool_handle();
		return HANDLE_W'($urandom_range(HANDLE_LO, HANDLE_HI));
	endfunction

	// hand one request word to the block, maybe after a random gap
	task automatic send_word(op_t op, logic p, logic [HANDLE_W-1:0] h);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid  <= 1'b1;
		opcode    <= op;
		pool      <= p;
		handle_in <= h;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// hold the input until every reply is back
	task automatic drain_replies();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	initial begin
		int r;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: lowest-slot allocation, range edges, double release, unused opcode
		send_word(OP_ALLOC, 1'b0, '0);
		send_word(OP_ALLOC, 1'b0, '1);
		send_word(OP_ALLOC, 1'b1, '0);
		send_word(OP_CHECK, 1'b0, 9'd2);
		send_word(OP_CHECK, 1'b0, 9'd3);
		send_word(OP_CHECK, 1'b0, 9'd4);
		send_word(OP_CHECK, 1'b0, 9'd0);
		send_word(OP_CHECK, 1'b0, 9'd1);
		send_word(OP_CHECK, 1'b0, 9'd256);
		send_word(OP_CHECK, 1'b0, 9'd257);
		send_word(OP_CHECK, 1'b0, 9'd511);
		send_word(OP_RELEASE, 1'b0, 9'd511);
		send_word(OP_RELEASE, 1'b0, 9'd0);
		send_word(OP_RELEASE, 1'b0, 9'd2);
		send_word(OP_RELEASE, 1'b0, 9'd2);
		send_word(OP_ALLOC, 1'b0, 9'h155);
		send_word(OP_RELEASE, 1'b1, 9'd3);
		send_word(OP_RELEASE, 1'b1, 9'd2);
		send_word(OP_NONE, 1'b0, 9'd511);
		send_word(OP_NONE, 1'b1, 9'h0aa);
		send_word(OP_CHECK, 1'b1, 9'd2);
		send_word(OP_ALLOC, 1'b1, 9'd0);
		drain_replies();

		// fill the ingress pool past exhaustion
		for (int n = 0; n < 300; n++) begin
			r = $urandom_range(0, 99);
			if (r < 92)
				send_word(OP_ALLOC, 1'b0, HANDLE_W'($urandom));
			else if (r < 96)
				send_word(OP_CHECK, 1'b0, pool_handle());
			else if (r < 98)
				send_word(OP_ALLOC, 1'b1, HANDLE_W'($urandom));
			else
				send_word(OP_NONE, 1'($urandom_range(0, 1)), HANDLE_W'($urandom));
		end
		drain_replies();

		// churn: mostly releases on a nearly full pool
		for (int n = 0; n < 150; n++) begin
			r = $urandom_range(0, 99);
			if (r < 55)
				send_word(OP_RELEASE, 1'b0, pool_handle());
			else if (r < 70)
				send_word(OP_ALLOC, 1'b0, HANDLE_W'($urandom));
			else if (r < 80)
				send_word(OP_CHECK, 1'b0, HANDLE_W'($urandom));
			else if (r < 95)
				send_word(op_t'($urandom_range(0, 2)), 1'b1, pool_handle());
			else
				send_word(OP_NONE, 1'($urandom_range(0, 1)), HANDLE_W'($urandom));
		end

		// fully mixed traffic, no idling in the last stretch
		for (int n = 0; n < 100; n++) begin
			if (n == 40)
				quiet = 1'b1;
			r = $urandom_range(0, 99);
			send_word(r < 30 ? OP_ALLOC : r < 60 ? OP_RELEASE : r < 85 ? OP_CHECK : OP_NONE,
				1'($urandom_range(0, 1)),
				$urandom_range(0, 1) ? pool_handle() : HANDLE_W'($urandom));
		end

		// wait out the last replies, then the verdict
		drain_replies();
		repeat (20) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// watchdog
	initial begin
		#400us;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
